FILE: rtl/rls_pe_pkg.sv
// Shared types, constants and fixed-point helpers of the RLS parameter estimator.
package rls_pe_pkg;

    localparam int VECTOR_DIM    = 3;
    localparam int FRACTION_BITS = 24;
    localparam int WORD_W        = 48;
    localparam int HALF_W        = WORD_W / 2;
    localparam int ACC_W         = WORD_W + 3;
    localparam int PROD_W        = 2 * WORD_W;
    localparam int QUOT_W        = WORD_W + FRACTION_BITS;
    localparam int LAMBDA_W      = 25;
    localparam int DELTA_W       = 47;
    localparam int CNT_W         = 32;
    localparam int CMD_W         = 2;

    // stream payload widths, rounded up to whole bytes
    localparam int S_TDATA_W = (((VECTOR_DIM + 1) * WORD_W + 7) / 8) * 8;
    localparam int M_TDATA_W = (((VECTOR_DIM + 1) * WORD_W + CNT_W + 7) / 8) * 8;

    localparam logic [LAMBDA_W-1:0] LAMBDA_RESET = 25'd16609444;
    localparam logic [DELTA_W-1:0]  DELTA_RESET  = 47'd1677721600;

    // small floors, nearest code and at least one code
    localparam longint ONE_Q       = longint'(1) << FRACTION_BITS;
    localparam longint EPS_DEN_RAW = (ONE_Q + 500000) / 1000000;
    localparam longint EPS_LAM_RAW = (ONE_Q + 500) / 1000;
    localparam longint EPS_DEN     = (EPS_DEN_RAW != 0) ? EPS_DEN_RAW : 1;
    localparam longint EPS_LAM     = (EPS_LAM_RAW != 0) ? EPS_LAM_RAW : 1;

    localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RESET  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd2;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic signed [ACC_W-1:0]  acc_t;

    localparam word_t EPS_DEN_W = word_t'(EPS_DEN);
    localparam word_t EPS_LAM_W = word_t'(EPS_LAM);

    typedef struct packed {
        logic [LAMBDA_W-1:0] lambda;
        logic [DELTA_W-1:0]  delta;
    } cfg_t;

    // saturate a wide signed sum to one word
    function automatic word_t sat_acc(acc_t v);
        acc_t  hi;
        acc_t  lo;
        word_t r;
        hi = {{(ACC_W-WORD_W+1){1'b0}}, {(WORD_W-1){1'b1}}};
        lo = ~hi;
        if (v > hi) begin
            r = {1'b0, {(WORD_W-1){1'b1}}};
        end else if (v < lo) begin
            r = {1'b1, {(WORD_W-1){1'b0}}};
        end else begin
            r = v[WORD_W-1:0];
        end
        return r;
    endfunction

    // magnitude of a word, 2^(W-1) fits as unsigned
    function automatic logic [WORD_W-1:0] mag(word_t v);
        logic [WORD_W-1:0] u;
        u = v;
        return v[WORD_W-1] ? (~u + 1'b1) : u;
    endfunction

    // clamp a magnitude against the word range and apply the sign
    function automatic word_t sat_mag(logic neg, logic [QUOT_W-1:0] m);
        logic [QUOT_W-1:0] lim;
        logic [QUOT_W-1:0] capped;
        logic [WORD_W-1:0] c;
        lim = neg ? {{(QUOT_W-WORD_W){1'b0}}, 1'b1, {(WORD_W-1){1'b0}}}
                  : {{(QUOT_W-WORD_W){1'b0}}, 1'b0, {(WORD_W-1){1'b1}}};
        capped = (m > lim) ? lim : m;
        c = capped[WORD_W-1:0];
        return neg ? word_t'(~c + 1'b1) : word_t'(c);
    endfunction

endpackage

FILE: rtl/rls_parameter_estimator_top.sv
// Top level of the RLS parameter estimator: register port and estimator core.
// Update: 54 multiplies and 12 divides, the divides on the shared radix-2 divider,
//   plus a sweep of the covariance memory when the covariance is reloaded.
// Reset command also sweeps the covariance memory; one item at a time.
// Result sits in an output register; the next item is taken while it waits.
// After aresetn (synchronous, active low) an init pass writes delta times identity
//   into the covariance memory before the first item is accepted.
module rls_parameter_estimator_top (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [3:0]                           paddr,
    input  logic [63:0]                          pwdata,
    output logic [63:0]                          prdata,
    output logic                                 pready,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // tdata: vector_elem_0, vector_elem_1, vector_elem_2, measured_output
    input  logic [rls_pe_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // tuser: command
    input  logic [rls_pe_pkg::CMD_W-1:0]         s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // tdata: estimate_0, estimate_1, estimate_2, prediction_error, update_count
    output logic [rls_pe_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    // tuser: covariance_reloaded
    output logic                                 m_axis_tuser
);

    localparam logic REG_LAMBDA = 1'b0;
    localparam logic REG_DELTA  = 1'b1;

    logic [rls_pe_pkg::LAMBDA_W-1:0] lambda_reg;
    logic [rls_pe_pkg::DELTA_W-1:0]  delta_reg;
    rls_pe_pkg::cfg_t                cfg;
    logic                            wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // register writes, one per access beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lambda_reg <= rls_pe_pkg::LAMBDA_RESET;
            delta_reg  <= rls_pe_pkg::DELTA_RESET;
        end else if (wr_en) begin
            case (paddr[3])
                REG_LAMBDA: lambda_reg <= pwdata[rls_pe_pkg::LAMBDA_W-1:0];
                REG_DELTA:  delta_reg  <= pwdata[rls_pe_pkg::DELTA_W-1:0];
                default:    lambda_reg <= lambda_reg;
            endcase
        end
    end

    // read back
    always_comb begin
        case (paddr[3])
            REG_LAMBDA: prdata = 64'(lambda_reg);
            REG_DELTA:  prdata = 64'(delta_reg);
            default:    prdata = '0;
        endcase
    end

    assign cfg.lambda = lambda_reg;
    assign cfg.delta  = delta_reg;

    rls_pe_core u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

FILE: rtl/rls_pe_core.sv
// RLS sequencer: covariance memory, shared multi-cycle multiplier and divider, result register.
module rls_pe_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  rls_pe_pkg::cfg_t                     cfg,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // tdata: vector_elem_0, vector_elem_1, vector_elem_2, measured_output
    input  logic [rls_pe_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // tuser: command
    input  logic [rls_pe_pkg::CMD_W-1:0]         s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // tdata: estimate_0, estimate_1, estimate_2, prediction_error, update_count
    output logic [rls_pe_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    // tuser: covariance_reloaded
    output logic                                 m_axis_tuser
);

    localparam int N      = rls_pe_pkg::VECTOR_DIM;
    localparam int W      = rls_pe_pkg::WORD_W;
    localparam int HW     = rls_pe_pkg::HALF_W;
    localparam int FB     = rls_pe_pkg::FRACTION_BITS;
    localparam int QW     = rls_pe_pkg::QUOT_W;
    localparam int PW     = rls_pe_pkg::PROD_W;
    localparam int NN     = N * N;
    localparam int IW     = (N > 1) ? $clog2(N) : 1;
    localparam int XW     = (NN > 1) ? $clog2(NN) : 1;
    localparam int DEPTH  = 2 * NN;
    localparam int AW     = $clog2(DEPTH);
    localparam int DCW    = $clog2(QW);

    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_SWEEP = 4'd2;
    localparam logic [3:0] S_RD    = 4'd3;
    localparam logic [3:0] S_MLOAD = 4'd4;
    localparam logic [3:0] S_MRUN  = 4'd5;
    localparam logic [3:0] S_MFIN  = 4'd6;
    localparam logic [3:0] S_MACC  = 4'd7;
    localparam logic [3:0] S_DIV   = 4'd8;
    localparam logic [3:0] S_DFIN  = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    localparam logic [2:0] PH_PX   = 3'd0;
    localparam logic [2:0] PH_XPX  = 3'd1;
    localparam logic [2:0] PH_GAIN = 3'd2;
    localparam logic [2:0] PH_XT   = 3'd3;
    localparam logic [2:0] PH_TH   = 3'd4;
    localparam logic [2:0] PH_KX   = 3'd5;
    localparam logic [2:0] PH_KP   = 3'd6;
    localparam logic [2:0] PH_KPD  = 3'd7;

    localparam logic [IW-1:0] LAST_I = IW'(N - 1);

    // flat matrix index
    function automatic logic [XW-1:0] fidx(logic [IW-1:0] r, logic [IW-1:0] c);
        return XW'(XW'(r) * XW'(N) + XW'(c));
    endfunction

    // memory address within a bank
    function automatic logic [AW-1:0] maddr(logic b, logic [XW-1:0] e);
        return b ? AW'(AW'(e) + AW'(NN)) : AW'(e);
    endfunction

    logic [3:0]     state_reg;
    logic [2:0]     phase_reg;
    logic [IW-1:0]  i_reg, j_reg, k_reg;
    logic           bank_reg;
    logic [rls_pe_pkg::CMD_W-1:0] cmd_reg;

    rls_pe_pkg::word_t x_reg     [N];
    rls_pe_pkg::word_t px_reg    [N];
    rls_pe_pkg::word_t gain_reg  [N];
    rls_pe_pkg::word_t theta_reg [N];
    rls_pe_pkg::word_t kx_reg    [NN];
    rls_pe_pkg::word_t y_reg, err_reg, den_reg, prod_reg;
    rls_pe_pkg::acc_t  acc_reg, trace_reg;
    logic              reload_reg;
    logic [rls_pe_pkg::CNT_W-1:0] count_reg;

    // multiplier state
    logic [W-1:0]  ua_reg, ub_reg;
    logic          mneg_reg;
    logic [1:0]    mstep_reg;
    logic [PW-1:0] macc_reg;

    // divider state
    logic [QW-1:0]  dnum_reg, quot_reg;
    logic [W:0]     rem_reg;
    logic [W-1:0]   dden_reg;
    logic           dneg_reg;
    logic [DCW-1:0] dcnt_reg;

    // output register
    logic                          m_valid_reg;
    logic [rls_pe_pkg::M_TDATA_W-1:0] m_data_reg;
    logic                          m_user_reg;
    logic [rls_pe_pkg::M_TDATA_W-1:0] out_data;

    // covariance memory, two banks
    rls_pe_pkg::word_t pmem [DEPTH];
    rls_pe_pkg::word_t mem_q_reg;
    logic [AW-1:0]     rd_addr, wr_addr;
    rls_pe_pkg::word_t wr_data;
    logic              mem_we;

    logic              s_fire, out_free, last_ij;
    rls_pe_pkg::word_t lam_w, lamf, op_a, op_b, div_q, diff, den_next, sw_delta;
    rls_pe_pkg::acc_t  acc_next, trace_next;
    logic [IW-1:0]     vsel;
    logic [HW-1:0]     ah, bh;
    logic [W-1:0]      pp;
    logic [PW-1:0]     pp_sh;
    logic [W:0]        rem2;
    logic              rem_ge;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign last_ij       = (i_reg == LAST_I) && (j_reg == LAST_I);

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    // result beat payload
    always_comb begin
        out_data = '0;
        for (int e = 0; e < N; e++) begin
            out_data[e*W +: W] = theta_reg[e];
        end
        out_data[N*W +: W] = err_reg;
        out_data[(N+1)*W +: rls_pe_pkg::CNT_W] = count_reg;
    end

    // lambda and its floor
    assign lam_w = rls_pe_pkg::word_t'({{(W-rls_pe_pkg::LAMBDA_W){1'b0}}, cfg.lambda});
    assign lamf  = (lam_w < rls_pe_pkg::EPS_LAM_W) ? rls_pe_pkg::EPS_LAM_W : lam_w;

    // operand selection for the shared multiplier
    assign vsel = (phase_reg == PH_PX || phase_reg == PH_KX) ? j_reg : i_reg;
    always_comb begin
        op_a = x_reg[vsel];
        op_b = px_reg[i_reg];
        case (phase_reg)
            PH_PX:   begin op_a = mem_q_reg;            op_b = x_reg[vsel];     end
            PH_XPX:  begin op_a = x_reg[vsel];          op_b = px_reg[i_reg];   end
            PH_XT:   begin op_a = x_reg[vsel];          op_b = theta_reg[i_reg]; end
            PH_TH:   begin op_a = gain_reg[i_reg];      op_b = err_reg;         end
            PH_KX:   begin op_a = gain_reg[i_reg];      op_b = x_reg[vsel];     end
            PH_KP:   begin op_a = kx_reg[fidx(i_reg, k_reg)]; op_b = mem_q_reg; end
            default: begin op_a = x_reg[vsel];          op_b = px_reg[i_reg];   end
        endcase
    end

    // one partial product per cycle
    assign ah = mstep_reg[1] ? ua_reg[W-1:HW] : ua_reg[HW-1:0];
    assign bh = mstep_reg[0] ? ub_reg[W-1:HW] : ub_reg[HW-1:0];
    assign pp = W'(ah) * W'(bh);
    always_comb begin
        case (mstep_reg)
            2'd0:    pp_sh = PW'(pp);
            2'd3:    pp_sh = PW'(pp) << (2 * HW);
            default: pp_sh = PW'(pp) << HW;
        endcase
    end

    // restoring division step
    assign rem2   = {rem_reg[W-1:0], dnum_reg[QW-1]};
    assign rem_ge = (rem2 >= {1'b0, dden_reg});
    assign div_q  = rls_pe_pkg::sat_mag(dneg_reg, quot_reg);

    // running sums
    assign acc_next   = acc_reg + rls_pe_pkg::acc_t'(prod_reg);
    assign trace_next = (i_reg == j_reg) ? trace_reg + rls_pe_pkg::acc_t'(div_q) : trace_reg;
    assign diff = rls_pe_pkg::sat_acc(rls_pe_pkg::acc_t'(mem_q_reg)
                                      - rls_pe_pkg::acc_t'(rls_pe_pkg::sat_acc(acc_reg)));

    // gain denominator with its floor
    always_comb begin
        den_next = rls_pe_pkg::sat_acc(rls_pe_pkg::acc_t'(lam_w)
                    + rls_pe_pkg::acc_t'(rls_pe_pkg::sat_acc(acc_next)));
        if (den_next < rls_pe_pkg::EPS_DEN_W) begin
            den_next = rls_pe_pkg::EPS_DEN_W;
        end
    end

    // memory ports
    assign sw_delta = rls_pe_pkg::word_t'({1'b0,
                        (state_reg == S_INIT) ? rls_pe_pkg::DELTA_RESET : cfg.delta});
    always_comb begin
        case (phase_reg)
            PH_KP:   rd_addr = maddr(bank_reg, fidx(k_reg, j_reg));
            default: rd_addr = maddr(bank_reg, fidx(i_reg, j_reg));
        endcase
        if (state_reg == S_INIT || state_reg == S_SWEEP) begin
            mem_we  = 1'b1;
            wr_addr = maddr(bank_reg, fidx(i_reg, j_reg));
            wr_data = (i_reg == j_reg) ? sw_delta : '0;
        end else begin
            mem_we  = (state_reg == S_DFIN) && (phase_reg == PH_KPD);
            wr_addr = maddr(!bank_reg, fidx(i_reg, j_reg));
            wr_data = div_q;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            pmem[wr_addr] <= wr_data;
        end
        mem_q_reg <= pmem[rd_addr];
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_INIT;
            phase_reg   <= PH_PX;
            i_reg       <= '0;
            j_reg       <= '0;
            k_reg       <= '0;
            bank_reg    <= 1'b0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            reload_reg  <= 1'b0;
            for (int e = 0; e < N; e++) begin
                theta_reg[e] <= '0;
            end
        end else begin
            // result valid: set when a beat is loaded, cleared when taken
            if (state_reg == S_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_INIT, S_SWEEP: begin
                    if (j_reg == LAST_I) begin
                        j_reg <= '0;
                        if (i_reg == LAST_I) begin
                            i_reg     <= '0;
                            state_reg <= (state_reg == S_INIT) ? S_IDLE : S_OUT;
                        end else begin
                            i_reg <= i_reg + 1'b1;
                        end
                    end else begin
                        j_reg <= j_reg + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (s_fire) begin
                        cmd_reg    <= s_axis_tuser;
                        err_reg    <= '0;
                        reload_reg <= 1'b0;
                        y_reg      <= s_axis_tdata[N*W +: W];
                        for (int e = 0; e < N; e++) begin
                            x_reg[e] <= s_axis_tdata[e*W +: W];
                        end
                        i_reg <= '0;
                        j_reg <= '0;
                        k_reg <= '0;
                        case (s_axis_tuser)
                            rls_pe_pkg::CMD_UPDATE: begin
                                phase_reg <= PH_PX;
                                acc_reg   <= '0;
                                state_reg <= S_RD;
                            end
                            rls_pe_pkg::CMD_RESET: begin
                                for (int e = 0; e < N; e++) begin
                                    theta_reg[e] <= '0;
                                end
                                count_reg <= '0;
                                state_reg <= S_SWEEP;
                            end
                            rls_pe_pkg::CMD_LOAD: begin
                                for (int e = 0; e < N; e++) begin
                                    theta_reg[e] <= s_axis_tdata[e*W +: W];
                                end
                                state_reg <= S_OUT;
                            end
                            default: state_reg <= S_OUT;
                        endcase
                    end
                end
                S_RD: state_reg <= S_MLOAD;
                S_MLOAD: begin
                    if (phase_reg == PH_KPD || phase_reg == PH_GAIN) begin
                        // start a division
                        dnum_reg  <= (phase_reg == PH_KPD)
                                     ? {rls_pe_pkg::mag(diff), {FB{1'b0}}}
                                     : {rls_pe_pkg::mag(px_reg[i_reg]), {FB{1'b0}}};
                        dneg_reg  <= (phase_reg == PH_KPD) ? diff[W-1] : px_reg[i_reg][W-1];
                        dden_reg  <= (phase_reg == PH_KPD) ? lamf : den_reg;
                        rem_reg   <= '0;
                        quot_reg  <= '0;
                        dcnt_reg  <= '0;
                        state_reg <= S_DIV;
                    end else begin
                        ua_reg    <= rls_pe_pkg::mag(op_a);
                        ub_reg    <= rls_pe_pkg::mag(op_b);
                        mneg_reg  <= op_a[W-1] ^ op_b[W-1];
                        mstep_reg <= '0;
                        macc_reg  <= '0;
                        state_reg <= S_MRUN;
                    end
                end
                S_MRUN: begin
                    macc_reg  <= macc_reg + pp_sh;
                    mstep_reg <= mstep_reg + 1'b1;
                    if (mstep_reg == 2'd3) begin
                        state_reg <= S_MFIN;
                    end
                end
                S_MFIN: begin
                    prod_reg  <= rls_pe_pkg::sat_mag(mneg_reg, macc_reg[PW-1:FB]);
                    state_reg <= S_MACC;
                end
                S_MACC: begin
                    state_reg <= S_RD;
                    case (phase_reg)
                        PH_PX: begin
                            if (j_reg == LAST_I) begin
                                px_reg[i_reg] <= rls_pe_pkg::sat_acc(acc_next);
                                acc_reg <= '0;
                                j_reg   <= '0;
                                if (i_reg == LAST_I) begin
                                    i_reg     <= '0;
                                    phase_reg <= PH_XPX;
                                end else begin
                                    i_reg <= i_reg + 1'b1;
                                end
                            end else begin
                                acc_reg <= acc_next;
                                j_reg   <= j_reg + 1'b1;
                            end
                        end
                        PH_XPX: begin
                            acc_reg <= acc_next;
                            if (i_reg == LAST_I) begin
                                den_reg   <= den_next;
                                i_reg     <= '0;
                                phase_reg <= PH_GAIN;
                            end else begin
                                i_reg <= i_reg + 1'b1;
                            end
                        end
                        PH_XT: begin
                            acc_reg <= acc_next;
                            if (i_reg == LAST_I) begin
                                err_reg <= rls_pe_pkg::sat_acc(rls_pe_pkg::acc_t'(y_reg)
                                    - rls_pe_pkg::acc_t'(rls_pe_pkg::sat_acc(acc_next)));
                                i_reg     <= '0;
                                phase_reg <= PH_TH;
                            end else begin
                                i_reg <= i_reg + 1'b1;
                            end
                        end
                        PH_TH: begin
                            theta_reg[i_reg] <= rls_pe_pkg::sat_acc(
                                rls_pe_pkg::acc_t'(theta_reg[i_reg])
                                + rls_pe_pkg::acc_t'(prod_reg));
                            if (i_reg == LAST_I) begin
                                i_reg     <= '0;
                                j_reg     <= '0;
                                phase_reg <= PH_KX;
                            end else begin
                                i_reg <= i_reg + 1'b1;
                            end
                        end
                        PH_KX: begin
                            kx_reg[fidx(i_reg, j_reg)] <= prod_reg;
                            if (j_reg == LAST_I) begin
                                j_reg <= '0;
                                if (i_reg == LAST_I) begin
                                    i_reg     <= '0;
                                    k_reg     <= '0;
                                    acc_reg   <= '0;
                                    trace_reg <= '0;
                                    phase_reg <= PH_KP;
                                end else begin
                                    i_reg <= i_reg + 1'b1;
                                end
                            end else begin
                                j_reg <= j_reg + 1'b1;
                            end
                        end
                        default: begin
                            // (K x') P, one term per pass
                            acc_reg <= acc_next;
                            if (k_reg == LAST_I) begin
                                k_reg     <= '0;
                                phase_reg <= PH_KPD;
                            end else begin
                                k_reg <= k_reg + 1'b1;
                            end
                        end
                    endcase
                end
                S_DIV: begin
                    dnum_reg <= {dnum_reg[QW-2:0], 1'b0};
                    rem_reg  <= rem_ge ? (rem2 - {1'b0, dden_reg}) : rem2;
                    quot_reg <= {quot_reg[QW-2:0], rem_ge};
                    dcnt_reg <= dcnt_reg + 1'b1;
                    if (dcnt_reg == DCW'(QW - 1)) begin
                        state_reg <= S_DFIN;
                    end
                end
                S_DFIN: begin
                    if (phase_reg == PH_GAIN) begin
                        state_reg <= S_RD;
                        gain_reg[i_reg] <= div_q;
                        if (i_reg == LAST_I) begin
                            i_reg     <= '0;
                            acc_reg   <= '0;
                            phase_reg <= PH_XT;
                        end else begin
                            i_reg <= i_reg + 1'b1;
                        end
                    end else begin
                        // new covariance entry went to the spare bank
                        trace_reg <= trace_next;
                        acc_reg   <= '0;
                        phase_reg <= PH_KP;
                        if (j_reg == LAST_I) begin
                            j_reg <= '0;
                            i_reg <= (i_reg == LAST_I) ? '0 : i_reg + 1'b1;
                        end else begin
                            j_reg <= j_reg + 1'b1;
                        end
                        if (last_ij) begin
                            bank_reg  <= !bank_reg;
                            count_reg <= count_reg + 1'b1;
                            if (trace_next < rls_pe_pkg::acc_t'(rls_pe_pkg::EPS_LAM_W)) begin
                                reload_reg <= 1'b1;
                                state_reg  <= S_SWEEP;
                            end else begin
                                state_reg  <= S_OUT;
                            end
                        end else begin
                            state_reg <= S_RD;
                        end
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        m_user_reg <= reload_reg;
                        m_data_reg <= out_data;
                        state_reg  <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    // divisor is always a positive floored value
    a_div_den_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) |-> (dden_reg != '0 && !dden_reg[W-1]))
        else $error("divider running with a zero or negative divisor");

    // non-update commands report no error and no reload
    a_nonupdate_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && cmd_reg != rls_pe_pkg::CMD_UPDATE)
        |-> (err_reg == '0 && !reload_reg))
        else $error("non-update command carries update status");

    // banks swap only at the end of the covariance update
    a_bank_swap: assert property (@(posedge aclk) disable iff (!aresetn)
        (bank_reg != $past(bank_reg)) |-> ($past(state_reg) == S_DFIN && $past(phase_reg) == PH_KPD))
        else $error("covariance bank swapped outside an update");
`endif

endmodule

FILE: sim/tb_rls_parameter_estimator_top.sv
// Self-checking testbench of the RLS parameter estimator: directed table, then random phases.
module tb_rls_parameter_estimator_top;

    localparam logic [rls_pe_pkg::CMD_W-1:0] CMD_NONE = 2'd3;
    localparam logic [3:0] ADDR_LAMBDA = 4'd0;
    localparam logic [3:0] ADDR_DELTA  = 4'd8;
    localparam longint WMAX = 64'sd140737488355327;
    localparam longint WMIN = -64'sd140737488355328;
    localparam longint ONE  = 64'sd16777216;
    localparam longint LAMBDA_MAX = 64'sd16777216;
    localparam longint DELTA_MAX  = 64'sd140737488355327;

    // one result beat
    typedef struct packed {
        logic [rls_pe_pkg::WORD_W-1:0] est0;
        logic [rls_pe_pkg::WORD_W-1:0] est1;
        logic [rls_pe_pkg::WORD_W-1:0] est2;
        logic [rls_pe_pkg::WORD_W-1:0] err;
        logic                          reloaded;
        logic [rls_pe_pkg::CNT_W-1:0]  count;
    } result_t;

    // directed row: input beat, plus a typed result where it is obvious
    typedef struct {
        logic [rls_pe_pkg::CMD_W-1:0] cmd;
        longint x0, x1, x2, y;
        bit     typed;
        longint e0, e1, e2, err;
        bit     rel;
        int     cnt;
    } row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0] paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic pready;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [rls_pe_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;
    logic [rls_pe_pkg::CMD_W-1:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [rls_pe_pkg::M_TDATA_W-1:0] m_axis_tdata;
    logic m_axis_tuser;

    rls_parameter_estimator_top DUT (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // predictor state
    longint covar [9];
    longint theta [3];
    longint lambda_q, delta_q;
    logic [rls_pe_pkg::CNT_W-1:0] updates_seen;

    result_t expected_results [$];
    int mismatches = 0;
    bit quiet = 1'b0;
    longint plant [3];

    function automatic longint sat48(longint v);
        if (v > WMAX) return WMAX;
        if (v < WMIN) return WMIN;
        return v;
    endfunction

    // clamp a magnitude to the word range, then apply the sign
    function automatic longint signed_clamp(logic neg, logic [95:0] m);
        logic [95:0] lim;
        lim = neg ? 96'h8000_0000_0000 : 96'h7FFF_FFFF_FFFF;
        if (m > lim) m = lim;
        return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
    endfunction

    function automatic longint qmul(longint a, longint b);
        logic [95:0] ma, mb;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        return signed_clamp((a < 0) != (b < 0), (ma * mb) >> rls_pe_pkg::FRACTION_BITS);
    endfunction

    function automatic longint qdiv(longint a, longint d);
        logic [95:0] ma, md;
        ma = (a < 0) ? -a : a;
        md = (d < 0) ? -d : d;
        if (md == 0) return (a == 0) ? 0 : signed_clamp(a < 0, 96'h1_0000_0000_0000_0000);
        return signed_clamp((a < 0) != (d < 0), (ma << rls_pe_pkg::FRACTION_BITS) / md);
    endfunction

    function automatic void reload_covar();
        for (int i = 0; i < 9; i++) covar[i] = (i % 4 == 0) ? delta_q : 0;
    endfunction

    // one command: RLS step with forgetting, reset or load; returns the result beat
    function automatic result_t rls_predict(logic [rls_pe_pkg::CMD_W-1:0] cmd, longint x0,
                                            longint x1, longint x2, longint y);
        longint x [3];
        longint px [3];
        longint gain [3];
        longint kx [9];
        longint nxt [9];
        longint acc, den, lam, err, trace;
        bit rel;
        result_t r;
        x[0] = x0; x[1] = x1; x[2] = x2;
        err = 0;
        rel = 0;
        if (cmd == rls_pe_pkg::CMD_UPDATE) begin
            for (int i = 0; i < 3; i++) begin
                acc = 0;
                for (int j = 0; j < 3; j++) acc += qmul(covar[3*i+j], x[j]);
                px[i] = sat48(acc);
            end
            acc = 0;
            for (int i = 0; i < 3; i++) acc += qmul(x[i], px[i]);
            den = sat48(lambda_q + sat48(acc));
            if (den < rls_pe_pkg::EPS_DEN) den = rls_pe_pkg::EPS_DEN;
            for (int i = 0; i < 3; i++) gain[i] = qdiv(px[i], den);
            acc = 0;
            for (int i = 0; i < 3; i++) acc += qmul(x[i], theta[i]);
            err = sat48(y - sat48(acc));
            for (int i = 0; i < 3; i++) theta[i] = sat48(theta[i] + qmul(gain[i], err));
            for (int i = 0; i < 3; i++)
                for (int k = 0; k < 3; k++) kx[3*i+k] = qmul(gain[i], x[k]);
            lam = (lambda_q < rls_pe_pkg::EPS_LAM) ? rls_pe_pkg::EPS_LAM : lambda_q;
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++) begin
                    acc = 0;
                    for (int k = 0; k < 3; k++) acc += qmul(kx[3*i+k], covar[3*k+j]);
                    nxt[3*i+j] = qdiv(sat48(covar[3*i+j] - sat48(acc)), lam);
                end
            trace = 0;
            for (int i = 0; i < 9; i++) begin
                covar[i] = nxt[i];
                if (i % 4 == 0) trace += nxt[i];
            end
            updates_seen++;
            if (trace < rls_pe_pkg::EPS_LAM) begin
                reload_covar();
                rel = 1;
            end
        end else if (cmd == rls_pe_pkg::CMD_RESET) begin
            reload_covar();
            theta[0] = 0; theta[1] = 0; theta[2] = 0;
            updates_seen = '0;
        end else if (cmd == rls_pe_pkg::CMD_LOAD) begin
            theta[0] = x0; theta[1] = x1; theta[2] = x2;
        end
        r.est0 = theta[0][47:0];
        r.est1 = theta[1][47:0];
        r.est2 = theta[2][47:0];
        r.err = err[47:0];
        r.reloaded = rel;
        r.count = updates_seen;
        return r;
    endfunction

    function automatic longint rand_word();
        logic [47:0] b;
        b = 48'({$urandom, $urandom});
        return longint'($signed(b));
    endfunction

    // values within +-4.0
    function automatic longint rand_modest();
        return longint'($urandom_range(0, 1 << 27)) - (longint'(1) << 26);
    endfunction

    // APB write: setup then access
    task automatic reg_write(logic [3:0] addr, longint value);
        @(negedge aclk);
        psel = 1'b1; pwrite = 1'b1; penable = 1'b0; paddr = addr; pwdata = value;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        if (addr == ADDR_LAMBDA) lambda_q = value & ((longint'(1) << rls_pe_pkg::LAMBDA_W) - 1);
        else delta_q = value & ((longint'(1) << rls_pe_pkg::DELTA_W) - 1);
    endtask

    // block must be idle before a register write
    task automatic drain();
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    // drive one input beat; called and returns at a falling edge
    task automatic send_beat(logic [rls_pe_pkg::CMD_W-1:0] cmd, longint x0, longint x1,
                             longint x2, longint y);
        if (!quiet && $urandom_range(3) == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge aclk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser = cmd;
        s_axis_tdata = {y[47:0], x2[47:0], x1[47:0], x0[47:0]};
        do @(posedge aclk); while (!s_axis_tready);
        @(negedge aclk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic send_predicted(logic [rls_pe_pkg::CMD_W-1:0] cmd, longint x0, longint x1,
                                  longint x2, longint y);
        expected_results.push_back(rls_predict(cmd, x0, x1, x2, y));
        send_beat(cmd, x0, x1, x2, y);
    endtask

    // random traffic: mostly plant-like updates, some noise and commands
    task automatic random_phase(int n);
        int r;
        longint x0, x1, x2, y;
        for (int i = 0; i < 3; i++) plant[i] = rand_modest();
        send_predicted(rls_pe_pkg::CMD_RESET, rand_word(), rand_word(), rand_word(),
                       rand_word());
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 70) begin
                x0 = rand_modest(); x1 = rand_modest(); x2 = rand_modest();
                y = sat48(qmul(plant[0], x0) + qmul(plant[1], x1) + qmul(plant[2], x2)
                          + longint'($urandom_range(0, 4096)) - 2048);
                send_predicted(rls_pe_pkg::CMD_UPDATE, x0, x1, x2, y);
            end else if (r < 78) begin
                send_predicted(rls_pe_pkg::CMD_UPDATE, rand_word(), rand_word(), rand_word(),
                               rand_word());
            end else if (r < 86) begin
                send_predicted(rls_pe_pkg::CMD_LOAD, rand_modest(), rand_modest(),
                               rand_modest(), rand_word());
            end else if (r < 90) begin
                send_predicted(rls_pe_pkg::CMD_LOAD, rand_word(), rand_word(), rand_word(),
                               rand_word());
            end else if (r < 95) begin
                send_predicted(rls_pe_pkg::CMD_RESET, rand_word(), rand_word(), rand_word(),
                               rand_word());
            end else begin
                send_predicted(CMD_NONE, rand_word(), rand_word(), rand_word(), rand_word());
            end
        end
    endtask

    // receiver stalls in random bursts
    int stall_left = 0;
    always @(negedge aclk) begin
        if (quiet || !aresetn) begin
            m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else if ($urandom_range(3) == 0) begin
            m_axis_tready <= 1'b0;
            stall_left <= $urandom_range(1, 16);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // result checker
    always @(posedge aclk) begin
        result_t got, want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.est0 = m_axis_tdata[47:0];
            got.est1 = m_axis_tdata[95:48];
            got.est2 = m_axis_tdata[143:96];
            got.err = m_axis_tdata[191:144];
            got.count = m_axis_tdata[223:192];
            got.reloaded = m_axis_tuser;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %h", got);
            end else begin
                want = expected_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: est %h %h %h err %h rel %b cnt %0d, expected %h %h %h err %h rel %b cnt %0d",
                                 got.est0, got.est1, got.est2, got.err, got.reloaded, got.count,
                                 want.est0, want.est1, want.est2, want.err, want.reloaded,
                                 want.count);
                end
            end
        end
    end

    initial begin
        #100000000;
        $display("rls_parameter_estimator_top test failed");
        $finish;
    end

    row_t rows [0:17];
    result_t typed_res;

    initial begin
        rows = '{
            '{rls_pe_pkg::CMD_RESET,  5, 6, 7, 8,           1, 0, 0, 0, 0, 0, 0},
            '{rls_pe_pkg::CMD_LOAD,   WMAX, WMIN, 1, 0,     1, WMAX, WMIN, 1, 0, 0, 0},
            '{CMD_NONE,   WMIN, WMIN, WMIN, WMAX, 1, WMAX, WMIN, 1, 0, 0, 0},
            // zero regressor: no gain, error is y itself
            '{rls_pe_pkg::CMD_UPDATE, 0, 0, 0, WMAX,        1, WMAX, WMIN, 1, WMAX, 0, 1},
            '{rls_pe_pkg::CMD_UPDATE, 0, 0, 0, WMIN,        1, WMAX, WMIN, 1, WMIN, 0, 2},
            '{rls_pe_pkg::CMD_LOAD,   0, 0, 0, 0,           1, 0, 0, 0, 0, 0, 2},
            '{rls_pe_pkg::CMD_UPDATE, ONE, 0, 0, 2*ONE,     0, 0, 0, 0, 0, 0, 0},
            '{rls_pe_pkg::CMD_UPDATE, WMAX, WMAX, WMAX, WMIN, 0, 0, 0, 0, 0, 0, 0},
            '{rls_pe_pkg::CMD_UPDATE, WMIN, WMIN, WMIN, WMAX, 0, 0, 0, 0, 0, 0, 0},
            '{rls_pe_pkg::CMD_UPDATE, -ONE, ONE/2, 3*ONE, ONE, 0, 0, 0, 0, 0, 0, 0},
            '{rls_pe_pkg::CMD_LOAD,   ONE, -ONE, 0, 0,      1, ONE, -ONE, 0, 0, 0, 6},
            '{rls_pe_pkg::CMD_UPDATE, ONE, ONE, ONE, 3*ONE, 0, 0, 0, 0, 0, 0, 0},
            '{rls_pe_pkg::CMD_UPDATE, 2*ONE, -ONE, ONE/4, -ONE, 0, 0, 0, 0, 0, 0, 0},
            '{rls_pe_pkg::CMD_UPDATE, -3*ONE, 5, -7, ONE/8, 0, 0, 0, 0, 0, 0, 0},
            '{rls_pe_pkg::CMD_UPDATE, 1, -1, 1, -1,         0, 0, 0, 0, 0, 0, 0},
            '{rls_pe_pkg::CMD_UPDATE, ONE, 0, -ONE, WMAX,   0, 0, 0, 0, 0, 0, 0},
            '{CMD_NONE,   -1, -1, -1, -1,       0, 0, 0, 0, 0, 0, 0},
            '{rls_pe_pkg::CMD_RESET,  -1, -1, -1, -1,       1, 0, 0, 0, 0, 0, 0}
        };
        lambda_q = rls_pe_pkg::LAMBDA_RESET;
        delta_q = rls_pe_pkg::DELTA_RESET;
        reload_covar();
        theta[0] = 0; theta[1] = 0; theta[2] = 0;
        updates_seen = '0;

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed table at reset configuration
        foreach (rows[i]) begin
            typed_res = rls_predict(rows[i].cmd, rows[i].x0, rows[i].x1, rows[i].x2, rows[i].y);
            if (rows[i].typed) begin
                typed_res.est0 = rows[i].e0[47:0];
                typed_res.est1 = rows[i].e1[47:0];
                typed_res.est2 = rows[i].e2[47:0];
                typed_res.err = rows[i].err[47:0];
                typed_res.reloaded = rows[i].rel;
                typed_res.count = rows[i].cnt;
            end
            expected_results.push_back(typed_res);
            send_beat(rows[i].cmd, rows[i].x0, rows[i].x1, rows[i].x2, rows[i].y);
        end

        // tiny lambda and tiny delta: covariance reloads every update
        drain();
        reg_write(ADDR_LAMBDA, 0);
        reg_write(ADDR_DELTA, 1);
        random_phase(250);

        // lambda of one, largest delta
        drain();
        reg_write(ADDR_LAMBDA, LAMBDA_MAX);
        reg_write(ADDR_DELTA, DELTA_MAX);
        random_phase(250);

        // random settings
        drain();
        reg_write(ADDR_LAMBDA, longint'($urandom_range(0, 1 << 24)));
        reg_write(ADDR_DELTA, longint'({$urandom, $urandom} % DELTA_MAX) + 1);
        random_phase(300);

        // delta changed between phases: takes effect at the next reset or reload
        drain();
        reg_write(ADDR_LAMBDA, rls_pe_pkg::LAMBDA_RESET);
        reg_write(ADDR_DELTA, 100 * ONE);
        random_phase(300);

        // last stretch at full rate
        quiet = 1'b1;
        random_phase(280);
        s_axis_tvalid = 1'b0;

        while (expected_results.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("rls_parameter_estimator_top test passed");
        end else begin
            $display("rls_parameter_estimator_top test failed");
        end
        $finish;
    end

endmodule
